// ===== rtl/core/lba_to_chs_track_cache_core_macros.svh =====
// ----------------------------------------------------------------------------
// lba_to_chs_track_cache_core assertion macros
// Shorthand for clocked implication checks with reset gating.
// ----------------------------------------------------------------------------
`ifndef LBA_TO_CHS_TRACK_CACHE_CORE_MACROS_SVH
`define LBA_TO_CHS_TRACK_CACHE_CORE_MACROS_SVH

// same-cycle implication
`define LBACHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBACHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lbachs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbachs_pkg
// Shared types, codes and constants for the LBA to CHS track cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbachs_pkg;

    // field widths
    localparam int unsigned FIELD_LBA_W = 24;
    localparam int unsigned CYL_W       = 24;
    localparam int unsigned HEAD_W      = 8;
    localparam int unsigned SEC_W       = 25;
    localparam int unsigned SPT_W       = 7;
    localparam int unsigned HEADS_W     = 9;
    localparam int unsigned OFF_W       = 6;
    localparam int unsigned CSTART_W    = 6;
    localparam int unsigned CLEN_W      = 5;
    localparam int unsigned NLEN_W      = 5;
    localparam int unsigned S_W         = 6;
    localparam int unsigned CHUNK_W     = 2;
    localparam int unsigned ACT_W       = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 9;

    // geometry limits
    localparam int unsigned MAX_CHUNK   = 22;
    localparam int unsigned MAX_SPT     = 63;
    localparam int unsigned MAX_HEADS   = 256;
    localparam int unsigned TAG_STRIDE  = 4;
    localparam int unsigned TAG_LO_W    = $clog2(TAG_STRIDE);

    // divide by 3 via reciprocal, exact for the 47..65 range used here
    localparam int unsigned RECIP3       = 171;
    localparam int unsigned RECIP3_SHIFT = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_HIT_RECENT = 3'd0,
        ACT_HIT_OLDER  = 3'd1,
        ACT_FILLED     = 3'd2,
        ACT_FILL_FAIL  = 3'd3,
        ACT_BAD_CHUNK  = 3'd4,
        ACT_BAD_GEO    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TRK,
        ST_CHUNK,
        ST_DIV_CYL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic commit;
        logic fill_ok;
        logic bad_geo;
        logic clear;
    } t_cache_ctl;

    typedef struct packed {
        t_action action;
        logic    slot;
    } t_cache_res;

    // chunk length: nlen = (spt + q) / (q + 1), q = (spt - 1) / 22
    function automatic logic [NLEN_W-1:0] f_nlen(input logic [S_W-1:0] spt);
        logic [S_W:0] sum1;
        logic [S_W:0] sum2;
        logic [15:0]  prod;
        sum1 = {1'b0, spt} + 7'd1;
        sum2 = {1'b0, spt} + 7'd2;
        prod = 16'(sum2) * 16'(RECIP3);
        if (spt <= S_W'(MAX_CHUNK)) begin
            return NLEN_W'(spt);
        end else if (spt <= S_W'(2 * MAX_CHUNK)) begin
            return NLEN_W'(sum1 >> 1);
        end else begin
            return NLEN_W'(prod >> RECIP3_SHIFT);
        end
    endfunction

endpackage

// ===== rtl/core/lba_to_chs_track_cache_core.sv =====
// Sequence: an accepted item runs the shared one-bit-per-cycle divider twice
//   (track, then cylinder) before the result is registered; bad geometry skips it.
// A new item is taken only once the previous one has left for the output register.
// Reset: synchronous, active low; geometry returns to 7 sectors and 2 heads,
//   both cache slots and the bad-chunk mark become invalid.
// ----------------------------------------------------------------------------
// lba_to_chs_track_cache_core
// Logical sector to cylinder/head/sector conversion with a two-entry chunk
// cache deciding hit, fill or single-sector fallback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lba_to_chs_track_cache_core #(
    parameter int LBA_WIDTH = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lbachs_pkg::FIELD_LBA_W-1:0]   i_logical_sector,
    input  logic                                 i_fill_ok,
    // result item channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [lbachs_pkg::ACT_W-1:0]         o_action,
    output logic [lbachs_pkg::CYL_W-1:0]         o_cylinder,
    output logic [lbachs_pkg::HEAD_W-1:0]        o_head,
    output logic [lbachs_pkg::SEC_W-1:0]         o_sector,
    output logic                                 o_slot,
    output logic [lbachs_pkg::OFF_W-1:0]         o_offset_in_chunk,
    output logic [lbachs_pkg::CSTART_W-1:0]      o_chunk_start,
    output logic [lbachs_pkg::CLEN_W-1:0]        o_chunk_length,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lbachs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbachs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lbachs_pkg::*;

    // Only the low LBA_WIDTH bits of the 24-bit field take part.
    localparam int LW = (LBA_WIDTH < FIELD_LBA_W) ? LBA_WIDTH : FIELD_LBA_W;
    // Chunk tag: cylinder*heads*4 + head*4 + chunk + 1 == track*4 + chunk + 1,
    // so the tag is just the track number with the chunk code below it.
    localparam int TW = LW + TAG_LO_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SPT_W-1:0]   r_spt;
    logic [HEADS_W-1:0] r_heads;
    logic               cfg_wr;
    logic               cfg_hit;
    t_state             r_state, n_state;

    // writes only land between items; an offered item goes first
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_in_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    // writes beyond the register list are dropped and leave the cache alone
    assign cfg_hit     = cfg_wr && ((i_cfg_index == CFG_SPT) || (i_cfg_index == CFG_HEADS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt   <= SPT_W'(7);
            r_heads <= HEADS_W'(2);
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_SPT) begin
                r_spt <= i_cfg_data[SPT_W-1:0];
            end
            if (i_cfg_index == CFG_HEADS) begin
                r_heads <= i_cfg_data[HEADS_W-1:0];
            end
        end
    end

    // Geometry is unusable for 0 or >63 sectors per track, 0 or >256 heads.
    logic bad_geo;
    assign bad_geo = (r_spt == '0) || (r_spt > SPT_W'(MAX_SPT))
                  || (r_heads == '0) || (r_heads > HEADS_W'(MAX_HEADS));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic    in_acc;
    logic    out_free;
    logic    div_start;
    logic    commit;
    logic    r_out_valid;
    logic [LW-1:0] r_trk;

    t_div_stat          div_stat;
    logic [LW-1:0]      div_dividend;
    logic [HEADS_W-1:0] div_divisor;
    logic [LW-1:0]      div_quot;
    logic [HEADS_W-1:0] div_rem;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    // the output register frees up in the same cycle it is taken
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (bad_geo) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state   = ST_DIV_TRK;
                        div_start = 1'b1;
                    end
                end
            end
            ST_DIV_TRK: begin
                if (div_stat.done) begin
                    n_state = ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                // second pass: track / heads
                div_start = 1'b1;
                n_state   = ST_DIV_CYL;
            end
            ST_DIV_CYL: begin
                if (div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider: first lba / spt, then track / heads
    // ------------------------------------------------------------------
    assign div_dividend = (r_state == ST_IDLE) ? i_logical_sector[LW-1:0] : r_trk;
    assign div_divisor  = (r_state == ST_IDLE) ? HEADS_W'(r_spt) : r_heads;

    lbachs_div #(
        .DW (LW),
        .VW (HEADS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // ------------------------------------------------------------------
    // Per-item working registers
    // ------------------------------------------------------------------
    logic [LW-1:0]       r_lba;
    logic                r_fill_ok;
    logic                r_bad_geo;
    logic [NLEN_W-1:0]   r_nlen;
    logic [S_W-1:0]      r_s;
    logic [LW-1:0]       r_cyl;
    logic [HEAD_W-1:0]   r_hd;
    logic [CHUNK_W-1:0]  r_chunk;
    logic [OFF_W-1:0]    r_off;
    logic [CSTART_W-1:0] r_cstart;
    logic [CLEN_W-1:0]   r_clen;

    // chunk split of the sector within the track; chunk never exceeds 2
    logic [S_W-1:0]      n1, n2, base, rest;
    logic [CHUNK_W-1:0]  n_chunk;
    logic [CLEN_W-1:0]   n_clen;

    always_comb begin
        n1   = S_W'(r_nlen);
        n2   = S_W'({r_nlen, 1'b0});
        priority if (r_s < n1) begin
            n_chunk = CHUNK_W'(0);
            base    = '0;
        end else if (r_s < n2) begin
            n_chunk = CHUNK_W'(1);
            base    = n1;
        end else begin
            n_chunk = CHUNK_W'(2);
            base    = n2;
        end
        // the last chunk is clipped at the track end
        rest   = r_spt[S_W-1:0] - base;
        n_clen = (rest < n1) ? CLEN_W'(rest) : r_nlen;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lba     <= i_logical_sector[LW-1:0];
            r_fill_ok <= i_fill_ok;
            r_bad_geo <= bad_geo;
            r_nlen    <= f_nlen(r_spt[S_W-1:0]);
        end
        if (r_state == ST_DIV_TRK && div_stat.done) begin
            r_s   <= div_rem[S_W-1:0];
            r_trk <= div_quot;
        end
        if (r_state == ST_CHUNK) begin
            r_chunk  <= n_chunk;
            r_off    <= OFF_W'(r_s - base);
            r_cstart <= CSTART_W'(base + S_W'(1));
            r_clen   <= n_clen;
        end
        if (r_state == ST_DIV_CYL && div_stat.done) begin
            r_hd  <= div_rem[HEAD_W-1:0];
            r_cyl <= div_quot;
        end
    end

    // ------------------------------------------------------------------
    // Chunk cache
    // ------------------------------------------------------------------
    logic [TW-1:0] tag;
    t_cache_ctl    cache_ctl;
    t_cache_res    cache_res;

    assign tag = {r_trk, TAG_LO_W'(r_chunk) + TAG_LO_W'(1)};

    assign cache_ctl.commit  = commit;
    assign cache_ctl.fill_ok = r_fill_ok;
    assign cache_ctl.bad_geo = r_bad_geo;
    assign cache_ctl.clear   = cfg_hit;

    lbachs_cache #(
        .TW (TW)
    ) u_cache (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag),
        .i_ctl   (cache_ctl),
        .o_res   (cache_res)
    );

    // ------------------------------------------------------------------
    // Output register: holds one finished item while the next is worked on
    // ------------------------------------------------------------------
    t_action             r_action;
    logic [CYL_W-1:0]    r_cyl_o;
    logic [HEAD_W-1:0]   r_head_o;
    logic [SEC_W-1:0]    r_sec_o;
    logic                r_slot_o;
    logic [OFF_W-1:0]    r_off_o;
    logic [CSTART_W-1:0] r_cstart_o;
    logic [CLEN_W-1:0]   r_clen_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_action <= cache_res.action;
            r_slot_o <= cache_res.slot;
            if (r_bad_geo) begin
                // raw number taken as the sector on cylinder 0, head 0
                r_cyl_o    <= '0;
                r_head_o   <= '0;
                r_sec_o    <= SEC_W'(r_lba) + SEC_W'(1);
                r_off_o    <= '0;
                r_cstart_o <= '0;
                r_clen_o   <= '0;
            end else begin
                r_cyl_o    <= CYL_W'(r_cyl);
                r_head_o   <= r_hd;
                r_sec_o    <= SEC_W'(r_s) + SEC_W'(1);
                r_off_o    <= r_off;
                r_cstart_o <= r_cstart;
                r_clen_o   <= r_clen;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_action;
    assign o_cylinder        = r_cyl_o;
    assign o_head            = r_head_o;
    assign o_sector          = r_sec_o;
    assign o_slot            = r_slot_o;
    assign o_offset_in_chunk = r_off_o;
    assign o_chunk_start     = r_cstart_o;
    assign o_chunk_length    = r_clen_o;

endmodule

// ===== rtl/core/lbachs_div.sv =====
// ----------------------------------------------------------------------------
// lbachs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbachs_div #(
    parameter int DW = 24,
    parameter int VW = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW-1:0]         i_dividend,
    input  logic [VW-1:0]         i_divisor,
    output lbachs_pkg::t_div_stat o_stat,
    output logic [DW-1:0]         o_quot,
    output logic [VW-1:0]         o_rem
);
    import lbachs_pkg::*;

    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    logic [DW-1:0] r_quot, n_quot;
    logic [VW-1:0] r_rem,  n_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem, r_quot[DW-1]};
        ge     = rem_sh >= {1'b0, r_div};
        diff   = rem_sh - {1'b0, r_div};
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[DW-2:0], ge};
            n_rem  = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            n_cnt  = r_cnt + CW'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
    assign o_rem       = r_rem;

endmodule

// ===== rtl/core/lbachs_cache.sv =====
// ----------------------------------------------------------------------------
// lbachs_cache
// Two-entry chunk tag cache with most-recent pointer and one bad-chunk tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbachs_cache #(
    parameter int TW = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [TW-1:0]          i_tag,
    input  lbachs_pkg::t_cache_ctl i_ctl,
    output lbachs_pkg::t_cache_res o_res
);
    import lbachs_pkg::*;

    logic [TW-1:0] r_tag0, r_tag1, n_tag0, n_tag1;
    logic [TW-1:0] r_bad_tag, n_bad_tag;
    logic [1:0]    r_valid, n_valid;
    logic          r_recent, n_recent;
    logic          r_bad_valid, n_bad_valid;

    logic eq0, eq1, hit_bad, hit_rec, hit_oth, oth;

    always_comb begin
        eq0     = r_valid[0] && (r_tag0 == i_tag);
        eq1     = r_valid[1] && (r_tag1 == i_tag);
        oth     = ~r_recent;
        hit_bad = r_bad_valid && (r_bad_tag == i_tag);
        hit_rec = r_recent ? eq1 : eq0;
        hit_oth = r_recent ? eq0 : eq1;

        o_res.action = ACT_FILLED;
        o_res.slot   = 1'b0;
        n_tag0       = r_tag0;
        n_tag1       = r_tag1;
        n_bad_tag    = r_bad_tag;
        n_valid      = r_valid;
        n_recent     = r_recent;
        n_bad_valid  = r_bad_valid;

        priority if (i_ctl.bad_geo) begin
            o_res.action = ACT_BAD_GEO;
            n_valid      = 2'b00;
        end else if (hit_bad) begin
            o_res.action = ACT_BAD_CHUNK;
            n_valid      = 2'b00;
        end else if (hit_rec) begin
            o_res.action = ACT_HIT_RECENT;
            o_res.slot   = r_recent;
        end else if (hit_oth) begin
            o_res.action = ACT_HIT_OLDER;
            o_res.slot   = oth;
            n_recent     = oth;
        end else begin
            // miss: older slot becomes recent and takes the fill
            n_recent    = oth;
            n_bad_valid = 1'b0;
            if (i_ctl.fill_ok) begin
                o_res.action = ACT_FILLED;
                o_res.slot   = oth;
                n_valid[oth] = 1'b1;
                if (oth) begin
                    n_tag1 = i_tag;
                end else begin
                    n_tag0 = i_tag;
                end
            end else begin
                o_res.action = ACT_FILL_FAIL;
                n_bad_tag    = i_tag;
                n_bad_valid  = 1'b1;
                n_valid      = 2'b00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 2'b00;
            r_recent    <= 1'b0;
            r_bad_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid     <= 2'b00;
            r_bad_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_valid     <= n_valid;
            r_recent    <= n_recent;
            r_bad_valid <= n_bad_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_tag0    <= n_tag0;
            r_tag1    <= n_tag1;
            r_bad_tag <= n_bad_tag;
        end
    end

endmodule

// ===== rtl/core/lbachs_chk.sv =====
// ----------------------------------------------------------------------------
// lbachs_chk
// Port-level checks for the LBA to CHS track cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lba_to_chs_track_cache_core_macros.svh"

module lbachs_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [lbachs_pkg::ACT_W-1:0]      o_action,
    input logic [lbachs_pkg::CYL_W-1:0]      o_cylinder,
    input logic [lbachs_pkg::HEAD_W-1:0]     o_head,
    input logic [lbachs_pkg::SEC_W-1:0]      o_sector,
    input logic                              o_slot,
    input logic [lbachs_pkg::OFF_W-1:0]      o_offset_in_chunk,
    input logic [lbachs_pkg::CSTART_W-1:0]   o_chunk_start,
    input logic [lbachs_pkg::CLEN_W-1:0]     o_chunk_length
);
    import lbachs_pkg::*;

    logic geo_res;
    logic fallback_res;
    logic chs_ok;

    assign geo_res      = o_out_valid && (o_action == ACT_BAD_GEO);
    assign fallback_res = o_out_valid && ((o_action == ACT_FILL_FAIL)
                       || (o_action == ACT_BAD_CHUNK) || (o_action == ACT_BAD_GEO));
    assign chs_ok       = (o_chunk_length != '0)
                       && (o_chunk_length <= CLEN_W'(MAX_CHUNK))
                       && (OFF_W'(o_chunk_length) > o_offset_in_chunk)
                       && ((SEC_W'(o_chunk_start) + SEC_W'(o_offset_in_chunk)) == o_sector);

    // one item at a time: an accepted item blocks the input next cycle
    `LBACHS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")
    // bad geometry maps to cylinder 0 head 0 with no chunk
    `LBACHS_ASSERT_SAME(a_geo_zero, i_clk, i_rst_n, geo_res, (o_cylinder == '0) && (o_head == '0) && (o_chunk_length == '0) && (o_chunk_start == '0), "bad geometry result not zeroed")
    // fallback results report slot 0
    `LBACHS_ASSERT_SAME(a_fallback_slot, i_clk, i_rst_n, fallback_res, !o_slot, "fallback result with nonzero slot")
    // sector lies inside the reported chunk
    `LBACHS_ASSERT_SAME(a_chunk_geom, i_clk, i_rst_n, o_out_valid && !geo_res, chs_ok, "sector outside reported chunk")

endmodule

bind lba_to_chs_track_cache_core lbachs_chk u_lbachs_chk (.*);
